// ===== design/mlcp_pkg.sv =====
`default_nettype none
package mlcp_pkg;

  localparam int LINE_LENGTH = 32;
  localparam int CNT_W       = $clog2(LINE_LENGTH);

  localparam logic [2:0] KIND_STOP    = 3'd0;
  localparam logic [2:0] KIND_FWD     = 3'd1;
  localparam logic [2:0] KIND_REV     = 3'd2;
  localparam logic [2:0] KIND_LEFT    = 3'd3;
  localparam logic [2:0] KIND_RIGHT   = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  localparam logic [2:0] STOP_MATCHED = 3'd4;
  localparam logic [2:0] STOP_FAILED  = 3'd7;

  localparam logic [1:0] PH_BLANKS = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [CNT_W-1:0] stored_count;
    logic [7:0]       first_byte;
    logic [2:0]       stop_match_progress;
    logic [1:0]       number_phase;
    logic             number_negative;
    logic [31:0]      number_magnitude;
    logic             text_ended;
  } line_state_t;

  typedef struct packed {
    logic [2:0]  command_kind;
    logic [31:0] speed_value;
  } line_cmd_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
  endfunction

  // Letters of "STOP" by position
  function automatic logic [7:0] stop_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h53;
      2'd1:    c = 8'h54;
      2'd2:    c = 8'h4F;
      default: c = 8'h50;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/mlcp_parse.sv =====
`default_nettype none
module mlcp_parse (
  input  wire mlcp_pkg::line_state_t st,
  input  wire logic [7:0]            byte_r,
  output mlcp_pkg::line_state_t      st_next,
  output logic                       res_valid,
  output mlcp_pkg::line_cmd_t        res
);

  logic [8:0]  pos;
  logic [35:0] mag_x10;
  logic [35:0] digit;
  logic [2:0]  kind;

  assign pos     = 9'(st.stored_count);
  assign digit   = 36'(byte_r - mlcp_pkg::CH_ZERO);
  assign mag_x10 = ({4'd0, st.number_magnitude} << 3) + ({4'd0, st.number_magnitude} << 1)
                   + digit;

  always_comb begin
    if (st.stop_match_progress == mlcp_pkg::STOP_MATCHED) begin
      kind = mlcp_pkg::KIND_STOP;
    end else if (st.first_byte == mlcp_pkg::CH_F) begin
      kind = mlcp_pkg::KIND_FWD;
    end else if (st.first_byte == mlcp_pkg::CH_B) begin
      kind = mlcp_pkg::KIND_REV;
    end else if (st.first_byte == mlcp_pkg::CH_L) begin
      kind = mlcp_pkg::KIND_LEFT;
    end else if (st.first_byte == mlcp_pkg::CH_R) begin
      kind = mlcp_pkg::KIND_RIGHT;
    end else begin
      kind = mlcp_pkg::KIND_INVALID;
    end
  end

  always_comb begin
    st_next          = st;
    res_valid        = 1'b0;
    res.command_kind = kind;
    res.speed_value  = '0;
    if (byte_r == mlcp_pkg::CH_CR) begin
      // ignored
    end else if (byte_r == mlcp_pkg::CH_LF) begin
      res_valid = 1'b1;
      if (kind != mlcp_pkg::KIND_STOP && kind != mlcp_pkg::KIND_INVALID) begin
        if (st.number_negative) begin
          res.speed_value = 32'd0 - st.number_magnitude;
        end else if (st.number_magnitude > mlcp_pkg::POS_MAX) begin
          res.speed_value = mlcp_pkg::POS_MAX;
        end else begin
          res.speed_value = st.number_magnitude;
        end
      end
      st_next = '0;
    end else if (pos < 9'(mlcp_pkg::LINE_LENGTH - 1)) begin
      st_next.stored_count = mlcp_pkg::CNT_W'(pos + 9'd1);
      if (!st.text_ended) begin
        if (byte_r == 8'd0) begin
          st_next.text_ended = 1'b1;
        end
        if (pos == 9'd0) begin
          st_next.first_byte = byte_r;
        end
        if (pos < 9'd4 && 9'(st.stop_match_progress) == pos) begin
          st_next.stop_match_progress = (byte_r == mlcp_pkg::stop_char(pos[1:0]))
                                        ? 3'(pos + 9'd1) : mlcp_pkg::STOP_FAILED;
        end
        if (pos >= 9'd1 && st.number_phase != mlcp_pkg::PH_DONE) begin
          if (byte_r >= mlcp_pkg::CH_ZERO && byte_r <= mlcp_pkg::CH_NINE) begin
            st_next.number_magnitude = (mag_x10 > 36'(mlcp_pkg::MAG_CAP))
                                       ? mlcp_pkg::MAG_CAP : mag_x10[31:0];
            st_next.number_phase     = mlcp_pkg::PH_DIGITS;
          end else if (st.number_phase == mlcp_pkg::PH_BLANKS
                       && mlcp_pkg::is_blank(byte_r)) begin
            // still skipping blanks
          end else if (st.number_phase == mlcp_pkg::PH_BLANKS
                       && (byte_r == mlcp_pkg::CH_PLUS || byte_r == mlcp_pkg::CH_MINUS)) begin
            st_next.number_negative = (byte_r == mlcp_pkg::CH_MINUS);
            st_next.number_phase    = mlcp_pkg::PH_SIGN;
          end else begin
            st_next.number_phase = mlcp_pkg::PH_DONE;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/motor_line_command_parser_core.sv =====
// A line feed request is held in the input register, then parsed into the result
//   queue, where its command waits at the output.
// Throughput: one byte request per cycle while the result queue can take a result;
//   a two-entry result queue lets bytes keep flowing while a finished command waits to be taken.
// Reset: rst is synchronous, active high; clears line state, input and queue.
`default_nettype none
module motor_line_command_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       command_kind,
  output logic signed [31:0] speed_value
);

  // input register
  logic       valid_r;
  logic [7:0] byte_r;

  // running line state
  mlcp_pkg::line_state_t st;
  mlcp_pkg::line_state_t st_next;
  logic                  res_valid;
  mlcp_pkg::line_cmd_t   res;

  // result queue: slot0 faces the output, slot1 is the skid entry
  mlcp_pkg::line_cmd_t slot0;
  mlcp_pkg::line_cmd_t slot1;
  logic [1:0]          count;

  logic pop;
  logic can_push;
  logic advance;
  logic push;

  mlcp_parse u_parse (
    .st        (st),
    .byte_r    (byte_r),
    .st_next   (st_next),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid    = (count != 2'd0);
  assign pop          = out_valid && !out_stall;
  assign can_push     = (count != 2'd2) || pop;
  // a held byte moves on only when a result, if it makes one, has room
  assign advance      = valid_r && can_push;
  assign push         = advance && res_valid;
  assign in_stall     = valid_r && !can_push;

  assign command_kind = slot0.command_kind;
  assign speed_value  = slot0.speed_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        slot1 <= res;
      end else begin
        slot0 <= res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

// ===== tb/motor_line_command_parser_core_tb.sv =====
`timescale 1ns / 1ps

// Line command parser: bytes go in one request at a time and every line feed
// must yield exactly one command. A predictor in this bench tracks the line as
// the block should and queues the command for each line feed it accepts. The
// monitor pops that queue on every command taken from the block.
module motor_line_command_parser_core_tb;

  // Bytes the package does not name
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  localparam logic [31:0] STOP_WORD    = "STOP";
  localparam logic [71:0] NEAR_LIMIT   = "214748364";  // 2^31 without its last digit
  localparam int          KEEP_MAX     = mlcp_pkg::LINE_LENGTH - 1;

  localparam int SETTLE_CYCLES = 8;     // margin after the result queue drains
  localparam int HOLD_CYCLES   = 400;   // long output hold-off

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        byte_in  = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        command_kind;
  logic signed [31:0] speed_value;

  motor_line_command_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_kind (command_kind),
    .speed_value  (speed_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run of this stimulus
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predicted line state
  // ---------------------------------------------------------------------------
  int          line_kept;    // bytes kept of the current line
  logic [7:0]  line_first;   // first kept byte
  logic [2:0]  stop_prog;    // leading letters of STOP matched, or STOP_FAILED
  logic [1:0]  num_phase;
  logic        num_neg;
  logic [31:0] num_mag;      // saturates at MAG_CAP
  logic        text_done;    // a NUL was kept; later bytes count but do nothing

  mlcp_pkg::line_cmd_t pending_commands[$];  // commands owed by the block, oldest first

  int error_count      = 0;
  int bytes_sent       = 0;  // accepted requests, CRs excluded
  int commands_checked = 0;
  int stalled_offers   = 0;  // cycles a byte request sat against in_stall

  int tx_gap_pct   = 27;
  int rx_stall_pct = 27;
  int hold_asks    = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  function automatic void clear_line();
    line_kept  = 0;
    line_first = CH_NUL;
    stop_prog  = 3'd0;
    num_phase  = mlcp_pkg::PH_BLANKS;
    num_neg    = 1'b0;
    num_mag    = 32'd0;
    text_done  = 1'b0;
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_VT, CH_FORMFEED: return 1'b1;
      default:                              return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] stop_letter(input int idx);
    return STOP_WORD[31 - 8*idx -: 8];
  endfunction

  // One byte of the speed field: blanks, a sign, then digits; anything else ends it
  function automatic void number_step(input logic [7:0] c);
    logic [63:0] grown;
    if (num_phase == mlcp_pkg::PH_DONE) return;
    if (c >= mlcp_pkg::CH_ZERO && c <= mlcp_pkg::CH_NINE) begin
      grown     = {32'd0, num_mag} * 10 + (c - mlcp_pkg::CH_ZERO);
      num_mag   = (grown > {32'd0, mlcp_pkg::MAG_CAP}) ? mlcp_pkg::MAG_CAP : grown[31:0];
      num_phase = mlcp_pkg::PH_DIGITS;
    end else if (num_phase == mlcp_pkg::PH_BLANKS && blank_char(c)) begin
      // still in the leading blanks
    end else if (num_phase == mlcp_pkg::PH_BLANKS
                 && (c == mlcp_pkg::CH_PLUS || c == mlcp_pkg::CH_MINUS)) begin
      num_neg   = (c == mlcp_pkg::CH_MINUS);
      num_phase = mlcp_pkg::PH_SIGN;
    end else begin
      num_phase = mlcp_pkg::PH_DONE;
    end
  endfunction

  function automatic void predict_line_byte(input logic [7:0] c);
    mlcp_pkg::line_cmd_t cmd;
    if (c == mlcp_pkg::CH_CR) return;
    if (c != mlcp_pkg::CH_LF) begin
      // past the kept length a byte is simply dropped
      if (line_kept < KEEP_MAX) begin
        line_kept++;
        if (!text_done) begin
          if (c == CH_NUL) text_done = 1'b1;
          if (line_kept == 1) line_first = c;
          if (line_kept <= 4 && stop_prog == line_kept - 1)
            stop_prog = (c == stop_letter(line_kept - 1)) ? line_kept[2:0]
                                                          : mlcp_pkg::STOP_FAILED;
          if (line_kept >= 2) number_step(c);
        end
      end
      return;
    end
    // line feed closes the line
    cmd.speed_value = 32'd0;
    if (stop_prog == mlcp_pkg::STOP_MATCHED) begin
      cmd.command_kind = mlcp_pkg::KIND_STOP;
    end else begin
      case (line_first)
        mlcp_pkg::CH_F: cmd.command_kind = mlcp_pkg::KIND_FWD;
        mlcp_pkg::CH_B: cmd.command_kind = mlcp_pkg::KIND_REV;
        mlcp_pkg::CH_L: cmd.command_kind = mlcp_pkg::KIND_LEFT;
        mlcp_pkg::CH_R: cmd.command_kind = mlcp_pkg::KIND_RIGHT;
        default:        cmd.command_kind = mlcp_pkg::KIND_INVALID;
      endcase
    end
    if (cmd.command_kind != mlcp_pkg::KIND_STOP && cmd.command_kind != mlcp_pkg::KIND_INVALID)
      cmd.speed_value = num_neg ? 32'd0 - num_mag
                                : ((num_mag > mlcp_pkg::POS_MAX) ? mlcp_pkg::POS_MAX : num_mag);
    pending_commands.push_back(cmd);
    clear_line();
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Monitor: each command taken is checked against the oldest prediction
  mlcp_pkg::line_cmd_t head_cmd;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_commands.size() == 0) begin
        $error("command with nothing predicted: command_kind %0d, speed_value %0d",
               command_kind, speed_value);
        error_count++;
      end else begin
        head_cmd = pending_commands.pop_front();
        commands_checked++;
        if (command_kind !== head_cmd.command_kind) begin
          $error("command_kind: expected %0d, actual %0d", head_cmd.command_kind, command_kind);
          error_count++;
        end
        if (speed_value !== head_cmd.speed_value) begin
          $error("speed_value: expected %0d, actual %0d",
                 $signed(head_cmd.speed_value), speed_value);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called and returning at a falling edge; in_valid is left high so a
  // back-to-back request never sees it dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      stalled_offers++;
      @(posedge clk);
    end
    predict_line_byte(c);
    if (c != mlcp_pkg::CH_CR) bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte_maybe_cr(input logic [7:0] c);
    if ($urandom_range(0, 99) < 6) send_byte(mlcp_pkg::CH_CR);
    send_byte(c);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid, then wait until every predicted command has come out
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_commands.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Blanks, optional sign, sometimes a NUL, digits and sometimes trailing junk
  task automatic send_number_field();
    logic [7:0] c;
    int         digits;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0:       c = CH_SPACE;
        1:       c = CH_TAB;
        2:       c = CH_VT;
        default: c = CH_FORMFEED;
      endcase
      send_byte_maybe_cr(c);
    end
    case ($urandom_range(0, 2))
      1:       send_byte_maybe_cr(mlcp_pkg::CH_PLUS);
      2:       send_byte_maybe_cr(mlcp_pkg::CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) send_byte_maybe_cr(CH_NUL);
    if ($urandom_range(0, 9) == 0) begin
      // straddle the saturation point
      for (int i = 0; i < 9; i++) send_byte_maybe_cr(NEAR_LIMIT[71 - 8*i -: 8]);
      send_byte_maybe_cr(8'(mlcp_pkg::CH_ZERO + $urandom_range(6, 9)));
    end else begin
      if ($urandom_range(0, 9) == 0)
        digits = $urandom_range(10, 14);
      else if ($urandom_range(0, 4) == 0)
        digits = $urandom_range(6, 9);
      else
        digits = $urandom_range(0, 5);
      repeat (digits) send_byte_maybe_cr(8'(mlcp_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte_maybe_cr(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_line();
    int         pick;
    int         letters;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      // motion command
      case ($urandom_range(0, 3))
        0:       c = mlcp_pkg::CH_F;
        1:       c = mlcp_pkg::CH_B;
        2:       c = mlcp_pkg::CH_L;
        default: c = mlcp_pkg::CH_R;
      endcase
      send_byte_maybe_cr(c);
      send_number_field();
    end else if (pick < 74) begin
      // STOP, now and then cut short or with a letter in the wrong case
      letters = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4;
      for (int i = 0; i < letters; i++)
        send_byte_maybe_cr(($urandom_range(0, 9) == 0) ? stop_letter(i) ^ 8'h20 : stop_letter(i));
      if ($urandom_range(0, 1) == 1) send_number_field();
    end else if (pick < 84) begin
      // overlong line: digits land around the kept limit, the rest is dropped
      send_byte_maybe_cr(($urandom_range(0, 1) == 1) ? mlcp_pkg::CH_F : mlcp_pkg::CH_L);
      repeat ($urandom_range(22, 34)) send_byte_maybe_cr(CH_SPACE);
      repeat ($urandom_range(1, 8))
        send_byte_maybe_cr(8'(mlcp_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else if (pick < 90) begin
      // empty or blank-only line
      repeat ($urandom_range(0, 2)) send_byte_maybe_cr(CH_SPACE);
    end else begin
      // noise
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(mlcp_pkg::CH_LF);
  endtask

  task automatic send_random_lines(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) send_random_line();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command kind, blanks and sign, CR, NUL, no digits, saturation, 0xFF
  task automatic test_directed();
    tx_gap_pct   = 27;
    rx_stall_pct = 27;
    send_string("STOP\n");
    send_byte(mlcp_pkg::CH_LF);        // empty line
    send_string("B\t-9\r\n");
    send_string("L4");
    send_byte(CH_NUL);                 // text ends here, the 7 is ignored
    send_string("7\n");
    send_string("R");
    send_byte(8'hFF);                  // no digits
    send_byte(mlcp_pkg::CH_LF);
    send_string("F2147483648\n");      // saturates high
    finish_phase();
  endtask

  task automatic test_random_idling();
    tx_gap_pct   = 27;
    rx_stall_pct = 27;
    send_random_lines(950);
    finish_phase();
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    send_random_lines(250);
    finish_phase();
  endtask

  // Receiver holds off while short lines keep coming, so the result queue
  // fills and the block has to stall its byte requests
  task automatic test_output_hold_off();
    tx_gap_pct   = 0;
    rx_stall_pct = 27;
    hold_asks++;
    for (int i = 0; i < 12; i++) send_string($sformatf("R%0d\n", i * 37));
    tx_gap_pct = 27;
    send_random_lines(60);
    finish_phase();
  endtask

  initial begin
    clear_line();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_idling();
    test_back_to_back();
    test_output_hold_off();

    $display("Run covered %0d byte requests and %0d commands checked;", bytes_sent,
             commands_checked);
    $display("byte requests were held by in_stall for %0d cycles in all.", stalled_offers);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
